// File: rtl/core/lcts_pkg.sv
// ----------------------------------------------------------------------------
// lcts_pkg - shared definitions for the load-cell tare and scale monitor
// Widths, reset values, register indexes, operation codes and the word
// that passes from the front end to the back end through the queue.
// ----------------------------------------------------------------------------
package lcts_pkg;

   // defaults for the top-level parameters
   localparam int SAMPLE_BITS_DEFAULT      = 24;
   localparam int CAL_DIVISOR_BASE_DEFAULT = 1000;

   // fixed field widths
   localparam int CFG_W     = 16;
   localparam int CSR_IDX_W = 2;
   localparam int MAG_W     = 25;
   localparam int DIVISOR_W = 17;
   // widest dividend over the whole SAMPLE_BITS range (32 + 1)
   localparam int WIDE_W    = 33;

   localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_SCALE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_TENSION   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_TENSION   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_TICKS = 2'd3;

   // register reset values
   localparam logic [CFG_W-1:0] CAL_SCALE_RESET     = 16'd999;
   localparam logic [CFG_W-1:0] MIN_TENSION_RESET   = 16'd0;
   localparam logic [CFG_W-1:0] MAX_TENSION_RESET   = 16'hffff;
   localparam logic [CFG_W-1:0] TIMEOUT_TICKS_RESET = 16'd20000;

   // operation codes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   // queue depth between front and back end
   localparam int QUEUE_DEPTH = 2;

   // classified word handed from the front end to the back end
   typedef struct packed {
      logic              op;
      logic              neg;
      logic              err;
      logic              tare;
      logic [WIDE_W-1:0] mag;
   } entry_type;

endpackage

// File: rtl/core/lcts_divprep.sv
// ----------------------------------------------------------------------------
// lcts_divprep - calibration divisor preparation
// Works out (cal_scale + 1) / CAL_DIVISOR_BASE by reciprocal multiplication
// after each write of the calibration word: the product is registered,
// then shifted and clamped to at least one into the divisor register.
// ----------------------------------------------------------------------------
module lcts_divprep #(
   parameter int CAL_DIVISOR_BASE = lcts_pkg::CAL_DIVISOR_BASE_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [lcts_pkg::CFG_W-1:0]      cal_value,
   output logic                            busy,
   output logic [lcts_pkg::DIVISOR_W-1:0]  divisor
);

   localparam int DW     = lcts_pkg::DIVISOR_W;
   // reciprocal is one bit wider than the dividend
   localparam int MB     = DW + 1;
   localparam int PW     = DW + MB;
   localparam int SH     = DW + $clog2(CAL_DIVISOR_BASE);
   localparam logic [63:0] POW_WIDE   = 64'd1 << SH;
   localparam logic [63:0] RECIP_WIDE = (POW_WIDE + 64'(CAL_DIVISOR_BASE) - 64'd1)
                                      / 64'(CAL_DIVISOR_BASE);
   localparam logic [MB-1:0] RECIP    = MB'(RECIP_WIDE);
   localparam int RST_Q  = (int'(lcts_pkg::CAL_SCALE_RESET) + 1) / CAL_DIVISOR_BASE;
   localparam int RST_D  = (RST_Q == 0) ? 1 : RST_Q;

   logic [DW-1:0] dividend;
   logic [DW-1:0] quo;
   logic [PW-1:0] prod_ff, prod_in;
   logic          busy_ff, busy_in;
   logic [DW-1:0] div_ff, div_in;

   // product with the rounded-up reciprocal, then shift and clamp
   always_comb begin
      dividend = DW'({1'b0, cal_value}) + DW'(1);
      quo      = DW'(prod_ff >> SH);
      prod_in  = prod_ff;
      busy_in  = 1'b0;
      div_in   = div_ff;
      if (start) begin
         prod_in = PW'(dividend) * PW'(RECIP);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         div_in = (quo == '0) ? DW'(1) : quo;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (reset) begin
         busy_ff <= 1'b0;
         div_ff  <= DW'(RST_D);
      end else begin
         busy_ff <= busy_in;
         div_ff  <= div_in;
      end
   end

   assign busy    = busy_ff;
   assign divisor = div_ff;

endmodule

// File: rtl/core/lcts_front.sv
// ----------------------------------------------------------------------------
// lcts_front - input acceptance and classification
// Holds the tare offset, the good-sample tick count and the error flag,
// and turns each accepted word into a signed magnitude for the back end.
// ----------------------------------------------------------------------------
module lcts_front #(
   parameter int SAMPLE_BITS = lcts_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_operation,
   input  logic signed [SAMPLE_BITS-1:0]     req_sample_value,
   input  logic                              req_zero_request,
   input  logic                              req_ready_stuck,
   input  logic [lcts_pkg::CFG_W-1:0]        timeout_ticks,
   input  logic                              stall,
   output logic                              push,
   output lcts_pkg::entry_type               entry
);

   localparam int MW = SAMPLE_BITS + 1;
   localparam int TW = lcts_pkg::CFG_W + 1;

   logic [SAMPLE_BITS-1:0] tare_ff, tare_in, tare_sel;
   logic [TW-1:0]          ticks_ff, ticks_in;
   logic                   err_ff, err_in;
   logic                   tare_done_ff, tare_done_in;
   logic [MW-1:0]          diff, mag;
   logic [TW-1:0]          lim, cnt_next, cnt_sat;

   assign req_ready = !stall;
   assign push      = req_valid && req_ready;

   // tare removal and magnitude
   always_comb begin
      tare_sel = req_zero_request ? req_sample_value : tare_ff;
      diff     = {req_sample_value[SAMPLE_BITS-1], req_sample_value}
               - {tare_sel[SAMPLE_BITS-1], tare_sel};
      mag      = diff[MW-1] ? MW'(~diff + MW'(1)) : diff;
   end

   // tick count with saturation
   always_comb begin
      lim      = TW'({1'b0, timeout_ticks}) + TW'(1);
      cnt_next = TW'(ticks_ff + TW'(1));
      cnt_sat  = (cnt_next > lim) ? lim : cnt_next;
   end

   // state update per accepted word
   always_comb begin
      tare_in      = tare_ff;
      ticks_in     = ticks_ff;
      err_in       = err_ff;
      tare_done_in = tare_done_ff;
      if (push) begin
         if (req_operation == lcts_pkg::OP_TICK) begin
            ticks_in = cnt_sat;
            err_in   = err_ff || (cnt_sat > TW'({1'b0, timeout_ticks}));
         end else begin
            if (req_zero_request) begin
               tare_in      = req_sample_value;
               tare_done_in = 1'b1;
            end
            if (req_ready_stuck) begin
               err_in = 1'b1;
            end else begin
               err_in   = 1'b0;
               ticks_in = '0;
            end
         end
      end
   end

   // word for the queue
   always_comb begin
      entry.op   = req_operation;
      entry.neg  = diff[MW-1];
      entry.err  = err_in;
      entry.tare = tare_done_in;
      entry.mag  = lcts_pkg::WIDE_W'(mag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tare_ff      <= '0;
         ticks_ff     <= '0;
         err_ff       <= 1'b0;
         tare_done_ff <= 1'b0;
      end else begin
         tare_ff      <= tare_in;
         ticks_ff     <= ticks_in;
         err_ff       <= err_in;
         tare_done_ff <= tare_done_in;
      end
   end

endmodule

// File: rtl/core/lcts_queue.sv
// ----------------------------------------------------------------------------
// lcts_queue - short queue between front and back end
// Two-entry first-in first-out store of classified words.
// ----------------------------------------------------------------------------
module lcts_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  lcts_pkg::entry_type  push_entry,
   output logic                 full,
   output logic                 valid,
   input  logic                 pop,
   output lcts_pkg::entry_type  pop_entry
);

   localparam int DEPTH = lcts_pkg::QUEUE_DEPTH;
   localparam int PW    = $clog2(DEPTH);
   localparam int NW    = $clog2(DEPTH + 1);

   lcts_pkg::entry_type slot_ff [DEPTH];
   logic [PW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]       count_ff, count_in;

   assign full      = (count_ff == NW'(DEPTH));
   assign valid     = (count_ff != '0);
   assign pop_entry = slot_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = push ? PW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? PW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = NW'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = NW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: rtl/core/lcts_back.sv
// ----------------------------------------------------------------------------
// lcts_back - scaling, threshold flags and result register
// Divides the magnitude by the calibration divisor one bit a cycle, sets
// the sign, underload and overload flags and holds the last result word.
// ----------------------------------------------------------------------------
module lcts_back #(
   parameter int SAMPLE_BITS = lcts_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_valid,
   input  lcts_pkg::entry_type                q_entry,
   output logic                               pop,
   input  logic [lcts_pkg::DIVISOR_W-1:0]     divisor,
   input  logic [lcts_pkg::CFG_W-1:0]         min_tension,
   input  logic [lcts_pkg::CFG_W-1:0]         max_tension,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [lcts_pkg::MAG_W-1:0]         rsp_force_magnitude,
   output logic                               rsp_force_negative,
   output logic                               rsp_sensor_error,
   output logic                               rsp_underload,
   output logic                               rsp_overload,
   output logic                               rsp_tare_done
);

   localparam int MW = SAMPLE_BITS + 1;
   localparam int DW = lcts_pkg::DIVISOR_W;
   localparam int CW = $clog2(MW);
   localparam int WW = lcts_pkg::WIDE_W;
   localparam int FW = lcts_pkg::CFG_W;
   localparam int MG = lcts_pkg::MAG_W;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DIV  = 2'd1;
   localparam logic [1:0] S_HOLD = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [MW-1:0] quo_ff, quo_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic          op_ff, op_in;
   logic          neg_ff, neg_in;
   logic          err_ff, err_in;
   logic          tare_ff, tare_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [MG-1:0] mag_ff, mag_in;
   logic          rneg_ff, rneg_in;
   logic          rerr_ff, rerr_in;
   logic          under_ff, under_in;
   logic          over_ff, over_in;
   logic          rtare_ff, rtare_in;

   logic [DW:0]   shifted;
   logic          take;
   logic [WW-1:0] q_wide;
   logic [MG-1:0] q_sat;
   logic [FW-1:0] q_low;
   logic          out_free;

   // one restoring divide step
   always_comb begin
      shifted = {rem_ff, quo_ff[MW-1]};
      take    = (shifted >= {1'b0, divisor});
      q_wide  = WW'(quo_ff);
      q_sat   = (q_wide > WW'(lcts_pkg::MAG_MAX)) ? lcts_pkg::MAG_MAX : q_wide[MG-1:0];
      q_low   = q_sat[FW-1:0];
   end

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign pop      = (state_ff == S_IDLE) && q_valid;

   // sequencer and result register
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      op_in        = op_ff;
      neg_in       = neg_ff;
      err_in       = err_ff;
      tare_in      = tare_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mag_in       = mag_ff;
      rneg_in      = rneg_ff;
      rerr_in      = rerr_ff;
      under_in     = under_ff;
      over_in      = over_ff;
      rtare_in     = rtare_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               op_in   = q_entry.op;
               neg_in  = q_entry.neg;
               err_in  = q_entry.err;
               tare_in = q_entry.tare;
               quo_in  = q_entry.mag[MW-1:0];
               rem_in  = '0;
               cnt_in  = '0;
               state_in = (q_entry.op == lcts_pkg::OP_TICK) ? S_HOLD : S_DIV;
            end
         end
         S_DIV: begin
            rem_in = take ? DW'(shifted - {1'b0, divisor}) : shifted[DW-1:0];
            quo_in = {quo_ff[MW-2:0], take};
            cnt_in = CW'(cnt_ff + 1'b1);
            if (cnt_ff == CW'(MW-1)) begin
               state_in = S_HOLD;
            end
         end
         S_HOLD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rerr_in      = err_ff;
               rtare_in     = tare_ff;
               if (op_ff == lcts_pkg::OP_SAMPLE) begin
                  mag_in   = q_sat;
                  rneg_in  = neg_ff && (quo_ff != '0);
                  under_in = (q_low < min_tension);
                  over_in  = (q_low > max_tension);
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      op_ff   <= op_in;
      neg_ff  <= neg_in;
      err_ff  <= err_in;
      tare_ff <= tare_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         mag_ff       <= '0;
         rneg_ff      <= 1'b0;
         rerr_ff      <= 1'b0;
         under_ff     <= 1'b0;
         over_ff      <= 1'b0;
         rtare_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         mag_ff       <= mag_in;
         rneg_ff      <= rneg_in;
         rerr_ff      <= rerr_in;
         under_ff     <= under_in;
         over_ff      <= over_in;
         rtare_ff     <= rtare_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_force_magnitude = mag_ff;
   assign rsp_force_negative  = rneg_ff;
   assign rsp_sensor_error    = rerr_ff;
   assign rsp_underload       = under_ff;
   assign rsp_overload        = over_ff;
   assign rsp_tare_done       = rtare_ff;

`ifndef SYNTHESIS
   // partial remainder stays below the divisor while dividing
   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (rem_ff < divisor))
      else $error("remainder not below divisor");

   // divisor is never zero
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (divisor != '0))
      else $error("zero divisor");

   // a tick word skips the divider
   a_tick_no_div: assert property (@(posedge clock) disable iff (reset)
      (pop && (q_entry.op == lcts_pkg::OP_TICK)) |=> (state_ff == S_HOLD))
      else $error("tick entered divider");

   // a result word is loaded only while the result register is free
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_HOLD) && rsp_valid_ff && !rsp_ready) |=> (state_ff == S_HOLD))
      else $error("result overwritten while waiting");
`endif

endmodule

// File: rtl/core/load_cell_tare_scale_monitor.sv
// A sample word goes from the queue through the bit-serial divider in the back end
// to the result register and rsp_valid; a tick word skips the divider.
// The back end takes a new word only once it has loaded the last result;
// a two-word queue lets input words be taken while the back end divides.
// After a calibration write, input is held off while the divisor is formed.
// Reset is synchronous, active high; the CSRs return to their documented reset values.
// ----------------------------------------------------------------------------
// load_cell_tare_scale_monitor - load-cell tare and scale monitor
// Removes a tare offset from signed samples, scales by the calibration
// divisor and reports force, sign, thresholds and sensor health.
// ----------------------------------------------------------------------------
module load_cell_tare_scale_monitor #(
   parameter int SAMPLE_BITS      = lcts_pkg::SAMPLE_BITS_DEFAULT,
   parameter int CAL_DIVISOR_BASE = lcts_pkg::CAL_DIVISOR_BASE_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_operation,
   input  logic signed [SAMPLE_BITS-1:0]      req_sample_value,
   input  logic                               req_zero_request,
   input  logic                               req_ready_stuck,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [lcts_pkg::MAG_W-1:0]         rsp_force_magnitude,
   output logic                               rsp_force_negative,
   output logic                               rsp_sensor_error,
   output logic                               rsp_underload,
   output logic                               rsp_overload,
   output logic                               rsp_tare_done,
   input  logic                               csr_write_enable,
   input  logic [lcts_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lcts_pkg::CFG_W-1:0]         csr_write_data
);

   logic [lcts_pkg::CFG_W-1:0]     cal_ff, cal_in;
   logic [lcts_pkg::CFG_W-1:0]     min_ff, min_in;
   logic [lcts_pkg::CFG_W-1:0]     max_ff, max_in;
   logic [lcts_pkg::CFG_W-1:0]     timeout_ff, timeout_in;
   logic                           cal_write;
   logic                           prep_busy;
   logic [lcts_pkg::DIVISOR_W-1:0] divisor;
   logic                           q_full, q_valid, push, pop;
   lcts_pkg::entry_type            push_entry, pop_entry;

   // configuration registers
   always_comb begin
      cal_in     = cal_ff;
      min_in     = min_ff;
      max_in     = max_ff;
      timeout_in = timeout_ff;
      cal_write  = 1'b0;
      if (csr_write_enable) begin
         unique case (csr_index)
            lcts_pkg::CSR_CAL_SCALE: begin
               cal_in    = csr_write_data;
               cal_write = 1'b1;
            end
            lcts_pkg::CSR_MIN_TENSION:   min_in     = csr_write_data;
            lcts_pkg::CSR_MAX_TENSION:   max_in     = csr_write_data;
            lcts_pkg::CSR_TIMEOUT_TICKS: timeout_in = csr_write_data;
            default: begin
               cal_write = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff     <= lcts_pkg::CAL_SCALE_RESET;
         min_ff     <= lcts_pkg::MIN_TENSION_RESET;
         max_ff     <= lcts_pkg::MAX_TENSION_RESET;
         timeout_ff <= lcts_pkg::TIMEOUT_TICKS_RESET;
      end else begin
         cal_ff     <= cal_in;
         min_ff     <= min_in;
         max_ff     <= max_in;
         timeout_ff <= timeout_in;
      end
   end

   // divisor from the calibration word
   lcts_divprep #(
      .CAL_DIVISOR_BASE (CAL_DIVISOR_BASE)
   ) u_divprep (
      .clock     (clock),
      .reset     (reset),
      .start     (cal_write),
      .cal_value (cal_in),
      .busy      (prep_busy),
      .divisor   (divisor)
   );

   // front end
   lcts_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_sample_value (req_sample_value),
      .req_zero_request (req_zero_request),
      .req_ready_stuck  (req_ready_stuck),
      .timeout_ticks    (timeout_ff),
      .stall            (q_full || prep_busy),
      .push             (push),
      .entry            (push_entry)
   );

   // queue between the two halves
   lcts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .valid      (q_valid),
      .pop        (pop),
      .pop_entry  (pop_entry)
   );

   // back end
   lcts_back #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .q_valid             (q_valid),
      .q_entry             (pop_entry),
      .pop                 (pop),
      .divisor             (divisor),
      .min_tension         (min_ff),
      .max_tension         (max_ff),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_force_magnitude (rsp_force_magnitude),
      .rsp_force_negative  (rsp_force_negative),
      .rsp_sensor_error    (rsp_sensor_error),
      .rsp_underload       (rsp_underload),
      .rsp_overload        (rsp_overload),
      .rsp_tare_done       (rsp_tare_done)
   );

endmodule
